// ----- rtl/core/circ_pkg.sv -----
// Shared types and constants for the three-point circumcircle pipeline.
// Depends on nothing; three_point_circumcircle and the testbench import it.
package circ_pkg;

    localparam int               COORD_W          = 32;
    localparam logic [31:0]      THRESHOLD_RESET  = 32'd66;
    localparam logic             REG_DEG_THRESHOLD = 1'b0;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic signed [COORD_W-1:0] third_x;
        logic signed [COORD_W-1:0] third_y;
        logic signed [COORD_W-1:0] third_z;
    } circ_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [COORD_W-1:0]        circle_radius;
        logic                      degenerate;
    } circ_out_t;

endpackage

// ----- rtl/core/three_point_circumcircle.sv -----
// Circumcircle of three 3D points in Q16.16. Throughput: one transaction per cycle; busy
// stays low. Depth is set by the chain of digit multipliers, the 64-bit radius divider
// and the 32-stage square root. Reset clears all valid bits and sets degenerate_threshold
// to 66.
module three_point_circumcircle
    import circ_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  circ_in_t    operands,
    output logic        result_valid,
    output circ_out_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW     = 66;
    localparam int PW     = 2 * AW;
    localparam int SW     = PW + 2;
    localparam int DIG_A  = 16;
    localparam int DIG_B  = 8;
    localparam int CQW    = 41;
    localparam int RQW    = 64;
    localparam int LAT_A  = (AW + DIG_A - 1) / DIG_A;
    localparam int LAT_B  = (33 + DIG_B - 1) / DIG_B;
    localparam int LAT_C  = (AW + DIG_B - 1) / DIG_B;
    localparam int L_MA   = 5 + LAT_A;
    localparam int L_S    = L_MA + 1;
    localparam int L_DEG  = L_S + 1;
    localparam int L_MB   = L_MA + LAT_B;
    localparam int L_ABS  = L_MB + 2;
    localparam int L_DVD  = L_MB + 3;
    localparam int L_CQ   = L_DVD + CQW + 1;
    localparam int L_CEN  = L_CQ + 1;
    localparam int L_P2   = L_MA + LAT_C;
    localparam int L_RQ   = L_P2 + RQW + 1;
    localparam int L_RT   = L_RQ + RQW / 2;

    localparam logic signed [42:0] CEN_MAX = 43'sd2147483647;
    localparam logic signed [42:0] CEN_MIN = -43'sd2147483648;

    // Configuration port.
    logic [31:0] thr_reg;
    logic [63:0] thr2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_DEG_THRESHOLD)
        begin
            thr_reg <= pwdata;
        end
    end

    always_ff @(posedge clk)
    begin
        thr2_reg <= 64'(thr_reg) * 64'(thr_reg);
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DEG_THRESHOLD) ? thr_reg : '0;
    assign busy   = 1'b0;

    // Valid bits for every level of the pipeline.
    logic [L_RT-1:0] vld_reg;
    logic            result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg          <= {vld_reg[L_RT-2:0], start && !busy};
            result_valid_reg <= vld_reg[L_RT-1];
        end
    end

    // Level 1: input capture.
    circ_in_t           op_reg;
    logic signed [31:0] pt [9];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg <= operands;
        end
    end

    assign pt[0] = op_reg.first_x;
    assign pt[1] = op_reg.first_y;
    assign pt[2] = op_reg.first_z;
    assign pt[3] = op_reg.second_x;
    assign pt[4] = op_reg.second_y;
    assign pt[5] = op_reg.second_z;
    assign pt[6] = op_reg.third_x;
    assign pt[7] = op_reg.third_y;
    assign pt[8] = op_reg.third_z;

    // Level 2: edge vectors.
    logic signed [32:0] u_reg [3];
    logic signed [32:0] v_reg [3];
    logic signed [32:0] w_reg [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            u_reg[k] <= 33'(pt[k]) - 33'(pt[k+3]);
            v_reg[k] <= 33'(pt[k+3]) - 33'(pt[k+6]);
            w_reg[k] <= 33'(pt[k]) - 33'(pt[k+6]);
        end
    end

    // Level 3: elementary products and edge magnitudes.
    logic signed [65:0] xp_next [6];
    logic signed [65:0] dp_next [15];
    logic signed [65:0] xp_reg  [6];
    logic signed [65:0] dp_reg  [15];
    logic [32:0]        wabs_reg [3];
    logic [32:0]        vabs_reg [3];
    logic [2:0]         wneg_reg;
    logic [2:0]         vneg_reg;

    always_comb
    begin
        xp_next[0] = u_reg[1] * v_reg[2];
        xp_next[1] = u_reg[2] * v_reg[1];
        xp_next[2] = u_reg[2] * v_reg[0];
        xp_next[3] = u_reg[0] * v_reg[2];
        xp_next[4] = u_reg[0] * v_reg[1];
        xp_next[5] = u_reg[1] * v_reg[0];
        for (int k = 0; k < 3; k++)
        begin
            dp_next[k]    = u_reg[k] * u_reg[k];
            dp_next[3+k]  = v_reg[k] * v_reg[k];
            dp_next[6+k]  = w_reg[k] * w_reg[k];
            dp_next[9+k]  = u_reg[k] * w_reg[k];
            dp_next[12+k] = u_reg[k] * v_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        xp_reg <= xp_next;
        dp_reg <= dp_next;
        for (int k = 0; k < 3; k++)
        begin
            wabs_reg[k] <= w_reg[k][32] ? 33'(-w_reg[k]) : 33'(w_reg[k]);
            vabs_reg[k] <= v_reg[k][32] ? 33'(-v_reg[k]) : 33'(v_reg[k]);
            wneg_reg[k] <= w_reg[k][32];
            vneg_reg[k] <= v_reg[k][32];
        end
    end

    // Level 4: cross product and dot products.
    logic signed [66:0] c_reg    [3];
    logic signed [66:0] dsum_reg [5];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            c_reg[k] <= 67'(xp_reg[2*k]) - 67'(xp_reg[2*k+1]);
        end
        for (int j = 0; j < 5; j++)
        begin
            dsum_reg[j] <= 67'(dp_reg[3*j]) + 67'(dp_reg[3*j+1]) + 67'(dp_reg[3*j+2]);
        end
    end

    // Level 5: magnitudes for the multiplier array.
    logic [AW-1:0] cabs_reg [3];
    logic [AW-1:0] uu_reg;
    logic [AW-1:0] vv_reg;
    logic [AW-1:0] ww_reg;
    logic [AW-1:0] uwabs_reg;
    logic [AW-1:0] uvabs_reg;
    logic          uwneg_reg;
    logic          uvneg_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            cabs_reg[k] <= c_reg[k][66] ? AW'(-c_reg[k]) : AW'(c_reg[k]);
        end
        uu_reg    <= dsum_reg[0][AW-1:0];
        vv_reg    <= dsum_reg[1][AW-1:0];
        ww_reg    <= dsum_reg[2][AW-1:0];
        uwabs_reg <= dsum_reg[3][66] ? AW'(-dsum_reg[3]) : AW'(dsum_reg[3]);
        uvabs_reg <= dsum_reg[4][66] ? AW'(-dsum_reg[4]) : AW'(dsum_reg[4]);
        uwneg_reg <= dsum_reg[3][66];
        uvneg_reg <= dsum_reg[4][66];
    end

    // Levels 5 to 10: first multiplier row.
    logic [PW-1:0] csq [3];
    logic [PW-1:0] p1;
    logic [PW-1:0] fa;
    logic [PW-1:0] fb;

    for (genvar k = 0; k < 3; k++)
    begin : g_csq
        circ_mul #(.WA(AW), .WB(AW), .DIG(DIG_A)) u_mul_csq
        (
            .clk (clk),
            .a   (cabs_reg[k]),
            .b   (cabs_reg[k]),
            .p   (csq[k])
        );
    end

    circ_mul #(.WA(AW), .WB(AW), .DIG(DIG_A)) u_mul_p1
    (
        .clk (clk),
        .a   (uu_reg),
        .b   (vv_reg),
        .p   (p1)
    );

    circ_mul #(.WA(AW), .WB(AW), .DIG(DIG_A)) u_mul_fa
    (
        .clk (clk),
        .a   (vv_reg),
        .b   (uwabs_reg),
        .p   (fa)
    );

    circ_mul #(.WA(AW), .WB(AW), .DIG(DIG_A)) u_mul_fb
    (
        .clk (clk),
        .a   (ww_reg),
        .b   (uvabs_reg),
        .p   (fb)
    );

    logic [AW-1:0]  ww_d;
    logic [1:0]     fsgn_d;
    logic [203:0]   edge_d;
    logic [32:0]    wabs_d [3];
    logic [32:0]    vabs_d [3];
    logic [2:0]     wneg_d;
    logic [2:0]     vneg_d;

    circ_dly #(.W(AW), .N(L_MA - 5)) u_dly_ww
    (
        .clk (clk),
        .d   (ww_reg),
        .q   (ww_d)
    );

    circ_dly #(.W(2), .N(L_MA - 5)) u_dly_fsgn
    (
        .clk (clk),
        .d   ({uwneg_reg, uvneg_reg}),
        .q   (fsgn_d)
    );

    circ_dly #(.W(204), .N(L_MA - 3)) u_dly_edge
    (
        .clk (clk),
        .d   ({wabs_reg[0], wabs_reg[1], wabs_reg[2], vabs_reg[0], vabs_reg[1],
               vabs_reg[2], wneg_reg, vneg_reg}),
        .q   (edge_d)
    );

    assign {wabs_d[0], wabs_d[1], wabs_d[2], vabs_d[0], vabs_d[1], vabs_d[2],
            wneg_d, vneg_d} = edge_d;

    // Level 11 and 12: squared cross magnitude and the collinearity test.
    logic [SW-1:0] s_reg;
    logic          deg_reg;

    always_ff @(posedge clk)
    begin
        s_reg   <= SW'(csq[0]) + SW'(csq[1]) + SW'(csq[2]);
        deg_reg <= (s_reg == '0) || (s_reg < SW'({thr2_reg, 32'd0}));
    end

    // Levels 10 to 15: center numerator products.
    logic [PW+32:0] m1 [3];
    logic [PW+32:0] m2 [3];
    logic [5:0]     msgn_d;

    for (genvar k = 0; k < 3; k++)
    begin : g_num
        circ_mul #(.WA(PW), .WB(33), .DIG(DIG_B)) u_mul_m1
        (
            .clk (clk),
            .a   (fa),
            .b   (wabs_d[k]),
            .p   (m1[k])
        );

        circ_mul #(.WA(PW), .WB(33), .DIG(DIG_B)) u_mul_m2
        (
            .clk (clk),
            .a   (fb),
            .b   (vabs_d[k]),
            .p   (m2[k])
        );
    end

    circ_dly #(.W(6), .N(L_MB - L_MA)) u_dly_msgn
    (
        .clk (clk),
        .d   ({fsgn_d[1] ^ wneg_d[2], fsgn_d[1] ^ wneg_d[1], fsgn_d[1] ^ wneg_d[0],
               fsgn_d[0] ^ vneg_d[2], fsgn_d[0] ^ vneg_d[1], fsgn_d[0] ^ vneg_d[0]}),
        .q   (msgn_d)
    );

    // Levels 16 to 18: signed numerator, magnitude and rounded dividend.
    logic [166:0] num_reg  [3];
    logic [166:0] nabs_reg [3];
    logic [2:0]   nneg_reg;
    logic [167:0] dvd_reg  [3];
    logic [SW:0]  dvs_reg;
    logic [SW-1:0] s_l17;
    logic [SW-1:0] s_l19;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            num_reg[k]  <= (msgn_d[3+k] ? -167'(m1[k]) : 167'(m1[k]))
                         - (msgn_d[k] ? -167'(m2[k]) : 167'(m2[k]));
            nabs_reg[k] <= num_reg[k][166] ? -num_reg[k] : num_reg[k];
            nneg_reg[k] <= num_reg[k][166];
            dvd_reg[k]  <= 168'(nabs_reg[k]) + 168'(s_l17);
        end
        dvs_reg <= {s_l17, 1'b0};
    end

    circ_dly #(.W(SW), .N(L_ABS - L_S)) u_dly_s17
    (
        .clk (clk),
        .d   (s_reg),
        .q   (s_l17)
    );

    circ_dly #(.W(SW), .N(L_P2 - L_ABS)) u_dly_s19
    (
        .clk (clk),
        .d   (s_l17),
        .q   (s_l19)
    );

    // Levels 18 to 61: center division and offset from the third point.
    logic [CQW-1:0] cq [3];
    logic [2:0]     covf;
    logic [2:0]     nneg_d;
    logic [95:0]    p3_d;
    logic signed [31:0] p3 [3];
    logic [31:0]    cen_reg [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_cdiv
        logic signed [42:0] csum;
        logic               sat;

        circ_div #(.WN(168), .WD(SW+1), .QW(CQW)) u_div_cen
        (
            .clk (clk),
            .n   (dvd_reg[k]),
            .d   (dvs_reg),
            .q   (cq[k]),
            .ovf (covf[k])
        );

        assign sat  = covf[k] || (cq[k][CQW-1] && (|cq[k][CQW-2:0]));
        assign csum = 43'(p3[k]) + (nneg_d[k] ? -43'(cq[k]) : 43'(cq[k]));

        always_ff @(posedge clk)
        begin
            if (sat)
            begin
                cen_reg[k] <= nneg_d[k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else if (csum > CEN_MAX)
            begin
                cen_reg[k] <= 32'h7FFF_FFFF;
            end
            else if (csum < CEN_MIN)
            begin
                cen_reg[k] <= 32'h8000_0000;
            end
            else
            begin
                cen_reg[k] <= csum[31:0];
            end
        end
    end

    circ_dly #(.W(3), .N(L_CQ - L_ABS)) u_dly_nneg
    (
        .clk (clk),
        .d   (nneg_reg),
        .q   (nneg_d)
    );

    circ_dly #(.W(96), .N(L_CQ - 1)) u_dly_p3
    (
        .clk (clk),
        .d   ({op_reg.third_x, op_reg.third_y, op_reg.third_z}),
        .q   (p3_d)
    );

    assign p3[0] = p3_d[95:64];
    assign p3[1] = p3_d[63:32];
    assign p3[2] = p3_d[31:0];

    // Levels 10 to 116: radius product, division and square root.
    logic [PW+AW-1:0] p2;
    logic [RQW-1:0]   rq;
    logic             rovf;
    logic             rovf_d;
    logic [RQW/2-1:0] rt;

    circ_mul #(.WA(PW), .WB(AW), .DIG(DIG_B)) u_mul_p2
    (
        .clk (clk),
        .a   (p1),
        .b   (ww_d),
        .p   (p2)
    );

    circ_div #(.WN(PW+AW), .WD(SW+2), .QW(RQW)) u_div_rad
    (
        .clk (clk),
        .n   (p2),
        .d   ({s_l19, 2'b00}),
        .q   (rq),
        .ovf (rovf)
    );

    circ_sqrt #(.W(RQW)) u_sqrt
    (
        .clk (clk),
        .x   (rq),
        .r   (rt)
    );

    circ_dly #(.W(1), .N(L_RT - L_RQ)) u_dly_rovf
    (
        .clk (clk),
        .d   (rovf),
        .q   (rovf_d)
    );

    // Alignment of the center and the flag with the radius.
    logic [95:0] cen_d;
    logic        deg_d;

    circ_dly #(.W(96), .N(L_RT - L_CEN)) u_dly_cen
    (
        .clk (clk),
        .d   ({cen_reg[0], cen_reg[1], cen_reg[2]}),
        .q   (cen_d)
    );

    circ_dly #(.W(1), .N(L_RT - L_DEG)) u_dly_deg
    (
        .clk (clk),
        .d   (deg_reg),
        .q   (deg_d)
    );

    // Level 117: result register.
    circ_out_t result_reg;

    always_ff @(posedge clk)
    begin
        result_reg.degenerate <= deg_d;
        if (deg_d)
        begin
            result_reg.center_x      <= '0;
            result_reg.center_y      <= '0;
            result_reg.center_z      <= '0;
            result_reg.circle_radius <= '0;
        end
        else
        begin
            result_reg.center_x      <= cen_d[95:64];
            result_reg.center_y      <= cen_d[63:32];
            result_reg.center_z      <= cen_d[31:0];
            result_reg.circle_radius <= rovf_d ? 32'hFFFF_FFFF : rt;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

`ifndef SYNTHESIS
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.degenerate |->
            (result.circle_radius == '0) && (result.center_x == '0) &&
            (result.center_y == '0) && (result.center_z == '0))
        else $error("degenerate transaction carries a nonzero result");

    a_zero_area: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[L_S-1] && (s_reg == '0) |=> deg_reg)
        else $error("coincident points not flagged degenerate");
`endif

endmodule

// ----- rtl/core/circ_dly.sv -----
// Fixed-length register delay line used to align operands between pipeline branches.
// Depends on nothing.
module circ_dly
#(
    parameter int W = 1,
    parameter int N = 1
)
(
    input  logic         clk,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sh_reg [N];

    always_ff @(posedge clk)
    begin
        sh_reg[0] <= d;
        for (int k = 1; k < N; k++)
        begin
            sh_reg[k] <= sh_reg[k-1];
        end
    end

    assign q = sh_reg[N-1];

endmodule

// ----- rtl/core/circ_mul.sv -----
// Pipelined unsigned multiplier, one digit of the second operand per stage.
// Depends on nothing.
module circ_mul
#(
    parameter int WA  = 66,
    parameter int WB  = 66,
    parameter int DIG = 16
)
(
    input  logic             clk,
    input  logic [WA-1:0]    a,
    input  logic [WB-1:0]    b,
    output logic [WA+WB-1:0] p
);

    localparam int NS  = (WB + DIG - 1) / DIG;
    localparam int WBP = NS * DIG;
    localparam int WP  = WA + WB;

    logic [WA-1:0]  a_reg   [NS];
    logic [WBP-1:0] b_reg   [NS];
    logic [WP-1:0]  acc_reg [NS];
    logic [WBP-1:0] b_ext;

    assign b_ext = WBP'(b);

    for (genvar k = 0; k < NS; k++)
    begin : g_st
        logic [WA-1:0]     a_in;
        logic [WBP-1:0]    b_in;
        logic [WP-1:0]     acc_in;
        logic [WA+DIG-1:0] pp;

        if (k == 0)
        begin : g_first
            assign a_in   = a;
            assign b_in   = b_ext;
            assign acc_in = '0;
        end
        else
        begin : g_rest
            assign a_in   = a_reg[k-1];
            assign b_in   = b_reg[k-1];
            assign acc_in = acc_reg[k-1];
        end

        assign pp = (WA+DIG)'(a_in) * (WA+DIG)'(b_in[k*DIG +: DIG]);

        always_ff @(posedge clk)
        begin
            a_reg[k]   <= a_in;
            b_reg[k]   <= b_in;
            acc_reg[k] <= acc_in + (WP'(pp) << (k*DIG));
        end
    end

    assign p = acc_reg[NS-1];

endmodule

// ----- rtl/core/circ_div.sv -----
// Pipelined restoring divider: one quotient bit per stage plus an overflow stage.
// Depends on nothing.
module circ_div
#(
    parameter int WN = 198,
    parameter int WD = 136,
    parameter int QW = 64
)
(
    input  logic          clk,
    input  logic [WN-1:0] n,
    input  logic [WD-1:0] d,
    output logic [QW-1:0] q,
    output logic          ovf
);

    localparam int RW = ((WN > WD + QW) ? WN : WD + QW) + 1;

    logic [RW-1:0] r_reg   [QW+1];
    logic [WD-1:0] d_reg   [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic          ovf_reg [QW+1];

    always_ff @(posedge clk)
    begin
        r_reg[0]   <= RW'(n);
        d_reg[0]   <= d;
        q_reg[0]   <= '0;
        ovf_reg[0] <= RW'(n) >= (RW'(d) << QW);
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_st
        logic [RW-1:0] t;
        logic          ge;

        assign t  = RW'(d_reg[k-1]) << (QW - k);
        assign ge = r_reg[k-1] >= t;

        always_ff @(posedge clk)
        begin
            r_reg[k]   <= ge ? (r_reg[k-1] - t) : r_reg[k-1];
            d_reg[k]   <= d_reg[k-1];
            q_reg[k]   <= q_reg[k-1] | (QW'(ge) << (QW - k));
            ovf_reg[k] <= ovf_reg[k-1];
        end
    end

    assign q   = q_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

// ----- rtl/core/circ_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on nothing.
module circ_sqrt
#(
    parameter int W = 64
)
(
    input  logic           clk,
    input  logic [W-1:0]   x,
    output logic [W/2-1:0] r
);

    localparam int NS = W / 2;

    logic [W-1:0] x_reg [NS];
    logic [W-1:0] r_reg [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_st
        logic [W-1:0] x_in;
        logic [W-1:0] r_in;
        logic [W-1:0] bit_k;
        logic [W-1:0] t;
        logic         ge;

        if (k == 0)
        begin : g_first
            assign x_in = x;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign x_in = x_reg[k-1];
            assign r_in = r_reg[k-1];
        end

        assign bit_k = W'(1) << (W - 2 - 2*k);
        assign t     = r_in + bit_k;
        assign ge    = x_in >= t;

        always_ff @(posedge clk)
        begin
            x_reg[k] <= ge ? (x_in - t) : x_in;
            r_reg[k] <= ge ? ((r_in >> 1) + bit_k) : (r_in >> 1);
        end
    end

    assign r = r_reg[NS-1][W/2-1:0];

endmodule

// ----- tb/tb_three_point_circumcircle.sv -----
// Self-checking testbench for three_point_circumcircle: directed table, then random triples.
// Depends on circ_pkg and three_point_circumcircle; results checked by table or local predictor.
`timescale 1ns / 100ps

module tb_three_point_circumcircle;
    import circ_pkg::*;

    localparam int LATENCY     = 117;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
    localparam logic [2:0] ADDR_UNUSED    = 3'd4;

    typedef struct {
        circ_in_t  pts;
        bit        literal;
        circ_out_t circle;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    circ_in_t    operands = '0;
    logic        result_valid;
    circ_out_t   result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [31:0] model_threshold;
    circ_out_t   circle_queue[$];
    int          error_count = 0;
    int          cycle_count = 0;
    stim_row_t   directed[$];

    three_point_circumcircle u_dut (
        .clk, .rst_n, .start, .busy, .operands, .result_valid, .result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #4 clk = ~clk;

    function automatic logic [63:0] isqrt64(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > x)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [255:0] sext(logic [31:0] x);
        return {{224{x[31]}}, x};
    endfunction

    function automatic circ_out_t predict_circle(circ_in_t a, logic [31:0] thr);
        logic [255:0] p[9];
        logic [255:0] u[3], v[3], w[3], c[3];
        logic [255:0] s, lim, uu, vv, ww, uw, uv, q, fa, fb, num, mag;
        logic [63:0]  thr2;
        longint       val;
        longint       base;
        logic         neg;
        circ_out_t    o;
        p[0] = sext(a.first_x);  p[1] = sext(a.first_y);  p[2] = sext(a.first_z);
        p[3] = sext(a.second_x); p[4] = sext(a.second_y); p[5] = sext(a.second_z);
        p[6] = sext(a.third_x);  p[7] = sext(a.third_y);  p[8] = sext(a.third_z);
        for (int k = 0; k < 3; k++)
        begin
            u[k] = p[k] - p[3+k];
            v[k] = p[3+k] - p[6+k];
            w[k] = p[k] - p[6+k];
        end
        c[0] = u[1]*v[2] - u[2]*v[1];
        c[1] = u[2]*v[0] - u[0]*v[2];
        c[2] = u[0]*v[1] - u[1]*v[0];
        s = c[0]*c[0] + c[1]*c[1] + c[2]*c[2];
        thr2 = 64'(thr) * 64'(thr);
        lim = 256'(thr2) << 32;
        o = '0;
        if (s == 0 || s < lim)
        begin
            o.degenerate = 1'b1;
            return o;
        end
        uu = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
        vv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
        ww = w[0]*w[0] + w[1]*w[1] + w[2]*w[2];
        uw = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
        uv = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
        q = (uu*vv*ww) / (s*4);
        o.circle_radius = (q[255:64] == 0) ? 32'(isqrt64(q[63:0])) : 32'hFFFF_FFFF;
        fa = vv*uw;
        fb = ww*uv;
        for (int k = 0; k < 3; k++)
        begin
            num = fa*w[k] - fb*v[k];
            neg = num[255];
            mag = neg ? -num : num;
            q = (mag + s) / (s*2);
            if (q[255:64] != 0 || q[63:0] > (64'd1 << 40))
            begin
                val = neg ? -64'sd2147483648 : 64'sd2147483647;
            end
            else
            begin
                base = longint'($signed(p[6+k][31:0]));
                val = neg ? base - longint'(q[63:0]) : base + longint'(q[63:0]);
                if (val > 64'sd2147483647)
                begin
                    val = 64'sd2147483647;
                end
                if (val < -64'sd2147483648)
                begin
                    val = -64'sd2147483648;
                end
            end
            case (k)
                0: o.center_x = val[31:0];
                1: o.center_y = val[31:0];
                default: o.center_z = val[31:0];
            endcase
        end
        return o;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (circle_queue.size() == 0)
            begin
                report("unexpected transaction", 32'(result.degenerate), 32'h0);
            end
            else
            begin
                circ_out_t want;
                want = circle_queue.pop_front();
                if (result.center_x !== want.center_x)
                    report("center_x", result.center_x, want.center_x);
                if (result.center_y !== want.center_y)
                    report("center_y", result.center_y, want.center_y);
                if (result.center_z !== want.center_z)
                    report("center_z", result.center_z, want.center_z);
                if (result.circle_radius !== want.circle_radius)
                    report("circle_radius", result.circle_radius, want.circle_radius);
                if (result.degenerate !== want.degenerate)
                    report("degenerate", 32'(result.degenerate), 32'(want.degenerate));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_threshold(logic [31:0] thr);
        logic [31:0] rd;
        apb_access(1'b1, ADDR_THRESHOLD, thr, rd);
        model_threshold = thr;
        apb_access(1'b0, ADDR_THRESHOLD, '0, rd);
        if (rd !== thr)
            report("threshold readback", rd, thr);
    endtask

    task automatic drain();
        while (circle_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic send_points(circ_in_t pts, bit literal, circ_out_t want);
        @(negedge clk);
        start <= 1'b1;
        operands <= pts;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        circle_queue.push_back(literal ? want : predict_circle(pts, model_threshold));
    endtask

    task automatic idle_cycles(int n);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    function automatic circ_in_t random_points();
        circ_in_t t;
        int mode;
        int sh;
        logic signed [31:0] dx, dy, dz, bx, by, bz;
        int kf;
        mode = $urandom_range(0, 9);
        t = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
        sh = $urandom_range(4, 24);
        if (mode < 6)
        begin
            t.first_x = $signed(t.first_x) >>> sh;
            t.first_y = $signed(t.first_y) >>> sh;
            t.first_z = $signed(t.first_z) >>> sh;
            t.second_x = $signed(t.second_x) >>> sh;
            t.second_y = $signed(t.second_y) >>> sh;
            t.second_z = $signed(t.second_z) >>> sh;
            t.third_x = $signed(t.third_x) >>> sh;
            t.third_y = $signed(t.third_y) >>> sh;
            t.third_z = $signed(t.third_z) >>> sh;
        end
        else if (mode < 8)
        begin
            bx = $signed(t.first_x) >>> 8;
            by = $signed(t.first_y) >>> 8;
            bz = $signed(t.first_z) >>> 8;
            dx = $signed(t.second_x) >>> 12;
            dy = $signed(t.second_y) >>> 12;
            dz = $signed(t.second_z) >>> 12;
            kf = $urandom_range(0, 6) - 3;
            t.first_x = bx; t.first_y = by; t.first_z = bz;
            t.second_x = bx + dx; t.second_y = by + dy; t.second_z = bz + dz;
            t.third_x = bx + kf*dx + (mode == 7 ? $urandom_range(0, 3) : 0);
            t.third_y = by + kf*dy;
            t.third_z = bz + kf*dz;
        end
        else if (mode == 8)
        begin
            t.second_x = t.first_x; t.second_y = t.first_y; t.second_z = t.first_z;
        end
        return t;
    endfunction

    function automatic circ_in_t pts_of(int x1, int y1, int z1, int x2, int y2, int z2,
                                        int x3, int y3, int z3);
        circ_in_t t;
        t = {x1, y1, z1, x2, y2, z2, x3, y3, z3};
        return t;
    endfunction

    task automatic add_row(circ_in_t pts, bit literal, circ_out_t want);
        stim_row_t r;
        r.pts = pts;
        r.literal = literal;
        r.circle = want;
        directed.push_back(r);
    endtask

    initial
    begin
        circ_out_t    degen;
        circ_out_t    none;
        logic [31:0]  rd;
        int           maxv;
        int           minv;
        int           one;
        int           sent;
        int           burst;
        logic [31:0]  thr_set[5];

        degen = '0;
        degen.degenerate = 1'b1;
        none = '0;
        maxv = 32'h7FFF_FFFF;
        minv = 32'h8000_0000;
        one = 32'h0001_0000;
        model_threshold = THRESHOLD_RESET;

        add_row(pts_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, degen);
        add_row(pts_of(maxv, maxv, maxv, maxv, maxv, maxv, maxv, maxv, maxv), 1'b1, degen);
        add_row(pts_of(minv, minv, minv, minv, minv, minv, minv, minv, minv), 1'b1, degen);
        add_row(pts_of(0, 0, 0, one, one, one, 2*one, 2*one, 2*one), 1'b1, degen);
        add_row(pts_of(minv, 0, 0, 0, 0, 0, maxv, 0, 0), 1'b1, degen);
        add_row(pts_of(one, 0, 0, 0, one, 0, 0, 0, 0), 1'b0, none);
        add_row(pts_of(0, 0, 0, 4*one, 0, 0, 0, 3*one, 0), 1'b0, none);
        add_row(pts_of(0, 0, one, 0, one, 0, one, 0, 0), 1'b0, none);
        add_row(pts_of(minv, minv, minv, maxv, minv, maxv, minv, maxv, maxv), 1'b0, none);
        add_row(pts_of(maxv, maxv, 0, minv, maxv, 0, maxv, minv, 0), 1'b0, none);
        add_row(pts_of(0, 0, 0, maxv, 1, 0, minv, 2, 0), 1'b0, none);
        add_row(pts_of(0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b0, none);
        add_row(pts_of(0, 0, 0, 300, 0, 0, 0, 300, 0), 1'b0, none);
        add_row(pts_of(0, 0, 0, 2*one, 0, 0, one, 1, 0), 1'b0, none);
        add_row(pts_of(-5*one, 7*one, -one, 3*one, -2*one, 9*one, one, one, -8*one), 1'b0, none);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apb_access(1'b0, ADDR_THRESHOLD, '0, rd);
        if (rd !== THRESHOLD_RESET)
            report("threshold after reset", rd, THRESHOLD_RESET);

        foreach (directed[i])
        begin
            send_points(directed[i].pts, directed[i].literal, directed[i].circle);
            if ($urandom_range(0, 2) == 0)
                idle_cycles($urandom_range(1, 3));
        end
        idle_cycles(1);
        drain();

        apb_access(1'b1, ADDR_UNUSED, 32'hDEAD_BEEF, rd);

        thr_set[0] = 32'd0;
        thr_set[1] = 32'hFFFF_FFFF;
        thr_set[2] = 32'd1;
        thr_set[3] = 32'h0000_0000 | $urandom_range(0, 32'h0010_0000);
        thr_set[4] = THRESHOLD_RESET;
        sent = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
            begin
                set_threshold(thr_set[ph-1]);
            end
            for (int n = 0; n < 100; n++)
            begin
                if (ph == 0 && n < 15)
                    send_points(directed[n].pts, 1'b0, none);
                else
                    send_points(random_points(), 1'b0, none);
                sent++;
                if (sent == 250)
                begin
                    idle_cycles(1);
                    drain();
                end
                burst = $urandom_range(0, 7);
                if (burst == 0)
                    idle_cycles($urandom_range(1, 20));
                else if (burst < 3)
                    idle_cycles($urandom_range(1, 3));
            end
            idle_cycles(1);
            drain();
        end

        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
